@@ rtl/ifcs_pkg.sv @@
// shared types and constants of the irc format code stripper
package ifcs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RegIdxW = 3;

  typedef logic [ByteW-1:0] byte_t;

  // fixed byte values
  localparam byte_t CommaByte  = 8'h2C;
  localparam byte_t DigitLow   = 8'h30;
  localparam byte_t DigitHigh  = 8'h39;

  // register reset values
  localparam byte_t BoldReset      = 8'd2;
  localparam byte_t ColorReset     = 8'd3;
  localparam byte_t NormalReset    = 8'd15;
  localparam byte_t ReverseReset   = 8'd22;
  localparam byte_t UnderlineReset = 8'd31;
  localparam byte_t BlinkReset     = 8'd6;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_BOLD      = 3'd0,
    REG_COLOR     = 3'd1,
    REG_NORMAL    = 3'd2,
    REG_REVERSE   = 3'd3,
    REG_UNDERLINE = 3'd4,
    REG_BLINK     = 3'd5
  } reg_idx_e;

  // colour sequence parser phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_COLOR = 6'b000010,
    PH_FG1   = 6'b000100,
    PH_FG2   = 6'b001000,
    PH_COMMA = 6'b010000,
    PH_BG1   = 6'b100000
  } phase_e;

  // one result item
  typedef struct packed {
    byte_t data;
    logic  valid;
    logic  eom;
  } result_t;

endpackage

@@ rtl/ifcs_intf.sv @@
// request channel interfaces of the irc format code stripper

interface ifcs_in_if;
  logic                  valid;
  logic                  ready;
  ifcs_pkg::byte_t       in_byte;
  logic                  last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ifcs_out_if;
  logic                  valid;
  logic                  ready;
  ifcs_pkg::byte_t       out_byte;
  logic                  byte_valid;
  logic                  end_of_message;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface ifcs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ifcs_pkg::RegIdxW-1:0]   index;
  ifcs_pkg::byte_t                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/irc_format_code_stripper_core.sv @@
// top level of the irc format code stripper
//
// Message bytes enter on in_i, one request per byte with last_byte marking
// the final byte of a message. Kept text leaves on out_o; each result has
// out_byte, byte_valid and end_of_message. Decoration codes and colour
// sequences are removed; a message's last byte always gives a result with
// end_of_message set, a bare marker (byte_valid low) if no text is left.
// cfg_i writes the six code registers; it is always ready and should only
// be used while the block is idle. Unknown indexes are ignored.
// Flow: a byte is registered in the input stage at acceptance and its results
// are then loaded into the result register, which drives out_o; while the
// result register is not free, the byte waits in the input stage.
// Throughput is one byte per cycle while the receiver is ready; a byte that
// yields two results (held comma plus text) holds the result register until
// both have been taken through its single output port, so the next byte waits.
// Reset clears both stages and returns the parser to idle, with the code
// registers at their default values. When the receiver stalls, the result
// register holds and the input stage fills, after which in_i.ready drops;
// bytes that give no result still drain through while the output stalls.
module irc_format_code_stripper_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  ifcs_in_if.sink        in_i,
  ifcs_out_if.source     out_o,
  ifcs_cfg_if.sink       cfg_i
);

  // code registers
  ifcs_pkg::byte_t bold_q, color_q, normal_q, reverse_q, underline_q, blink_q;

  // input stage
  logic            s1_valid_q;
  ifcs_pkg::byte_t s1_byte_q;
  logic            s1_last_q;
  logic            s1_pop;

  // parser state
  ifcs_pkg::phase_e phase_q, phase_d;

  // result stage
  ifcs_pkg::result_t res_q [2];
  ifcs_pkg::result_t res_d [2];
  logic [1:0]        cnt_q;
  logic              head_q;
  logic              res_free;

  // decode of the staged byte
  logic       is_digit, is_comma, colour_hit, is_drop;
  logic       use_fresh, pre_comma, byte_emit, end_comma;
  logic [1:0] n_emit, n_out;
  ifcs_pkg::phase_e phase_seq;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bold_q      <= ifcs_pkg::BoldReset;
      color_q     <= ifcs_pkg::ColorReset;
      normal_q    <= ifcs_pkg::NormalReset;
      reverse_q   <= ifcs_pkg::ReverseReset;
      underline_q <= ifcs_pkg::UnderlineReset;
      blink_q     <= ifcs_pkg::BlinkReset;
    end else if (cfg_i.valid) begin
      unique case (ifcs_pkg::reg_idx_e'(cfg_i.index))
        ifcs_pkg::REG_BOLD:      bold_q      <= cfg_i.data;
        ifcs_pkg::REG_COLOR:     color_q     <= cfg_i.data;
        ifcs_pkg::REG_NORMAL:    normal_q    <= cfg_i.data;
        ifcs_pkg::REG_REVERSE:   reverse_q   <= cfg_i.data;
        ifcs_pkg::REG_UNDERLINE: underline_q <= cfg_i.data;
        ifcs_pkg::REG_BLINK:     blink_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  assign in_i.ready = !s1_valid_q || s1_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // byte classes
  assign is_digit = (s1_byte_q >= ifcs_pkg::DigitLow) && (s1_byte_q <= ifcs_pkg::DigitHigh);
  assign is_comma = (s1_byte_q == ifcs_pkg::CommaByte);
  assign colour_hit = (s1_byte_q == color_q);
  assign is_drop  = (s1_byte_q == bold_q) || (s1_byte_q == normal_q) ||
                    (s1_byte_q == reverse_q) || (s1_byte_q == underline_q) ||
                    (s1_byte_q == blink_q);

  // colour sequence parser
  always_comb begin
    phase_seq = ifcs_pkg::PH_IDLE;
    use_fresh = 1'b0;
    pre_comma = 1'b0;
    unique case (phase_q)
      ifcs_pkg::PH_COLOR: begin
        if (is_digit) phase_seq = ifcs_pkg::PH_FG1;
        else          use_fresh = 1'b1;
      end
      ifcs_pkg::PH_FG1: begin
        if (is_digit)      phase_seq = ifcs_pkg::PH_FG2;
        else if (is_comma) phase_seq = ifcs_pkg::PH_COMMA;
        else               use_fresh = 1'b1;
      end
      ifcs_pkg::PH_FG2: begin
        if (is_comma) phase_seq = ifcs_pkg::PH_COMMA;
        else          use_fresh = 1'b1;
      end
      ifcs_pkg::PH_COMMA: begin
        if (is_digit) begin
          phase_seq = ifcs_pkg::PH_BG1;
        end else begin
          pre_comma = 1'b1;
          use_fresh = 1'b1;
        end
      end
      ifcs_pkg::PH_BG1: begin
        if (is_digit) phase_seq = ifcs_pkg::PH_IDLE;
        else          use_fresh = 1'b1;
      end
      default: use_fresh = 1'b1;
    endcase

    // byte handled as if outside any sequence
    byte_emit = 1'b0;
    if (use_fresh) begin
      phase_seq = colour_hit ? ifcs_pkg::PH_COLOR : ifcs_pkg::PH_IDLE;
      byte_emit = !colour_hit && !is_drop;
    end

    // held comma flushed at end of message
    end_comma = s1_last_q && (phase_seq == ifcs_pkg::PH_COMMA);
    phase_d   = s1_last_q ? ifcs_pkg::PH_IDLE : phase_seq;
  end

  assign n_emit = {1'b0, pre_comma} + {1'b0, byte_emit} + {1'b0, end_comma};
  assign n_out  = (s1_last_q && (n_emit == 2'd0)) ? 2'd1 : n_emit;

  // result items, comma first when two
  always_comb begin
    res_d[0].data  = (pre_comma || end_comma) ? ifcs_pkg::CommaByte :
                     (byte_emit ? s1_byte_q : '0);
    res_d[0].valid = (n_emit != 2'd0);
    res_d[0].eom   = s1_last_q && (n_emit != 2'd2);
    res_d[1].data  = s1_byte_q;
    res_d[1].valid = 1'b1;
    res_d[1].eom   = s1_last_q;
  end

  // stage handover
  assign res_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign s1_pop   = s1_valid_q && ((n_out == 2'd0) || res_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ifcs_pkg::PH_IDLE;
    end else if (s1_pop) begin
      phase_q <= phase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else if (s1_pop && (n_out != 2'd0)) begin
      cnt_q  <= n_out;
      head_q <= 1'b0;
    end else if (out_o.valid && out_o.ready) begin
      cnt_q  <= cnt_q - 2'd1;
      head_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_pop && (n_out != 2'd0)) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
    end
  end

  // output channel
  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.out_byte       = res_q[head_q].data;
  assign out_o.byte_valid     = res_q[head_q].valid;
  assign out_o.end_of_message = res_q[head_q].eom;

endmodule
